/* hdl/tsm_pkg.sv */
`timescale 1ns / 1ps
// tail surface mixer package: item and config types, fixed-point constants,
// and the per-stage datapath functions used by the pipeline in the top level
// no dependencies
package tsm_pkg;

  // register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_ENABLE    = 3'd0,
    REG_YAW_MIX   = 3'd1,
    REG_ROLL_MIX  = 3'd2,
    REG_PITCH_MIX = 3'd3,
    REG_ROT_LIMIT = 3'd4,
    REG_COUP_GAIN = 3'd5
  } reg_idx_t;

  localparam int ADDR_W = 5;

  localparam logic        RST_ENABLE    = 1'b1;
  localparam logic [14:0] RST_YAW_MIX   = 15'd13107;
  localparam logic [14:0] RST_ROLL_MIX  = 15'd2458;
  localparam logic [14:0] RST_PITCH_MIX = 15'd16384;
  localparam logic [12:0] RST_ROT_LIMIT = 13'd4500;

  typedef struct packed {
    logic               enable;
    logic [14:0]        yaw_mix;
    logic [14:0]        roll_mix;
    logic [14:0]        pitch_mix;
    logic [12:0]        rot_limit;
    logic signed [16:0] coup_gain;
  } cfg_t;

  // pipeline stage map
  localparam int NSTAGE       = 21;
  localparam int ST_ENTRY     = 0;
  localparam int ST_ROUND     = 1;
  localparam int ST_ANGLE     = 2;
  localparam int ST_SQUARE    = 3;
  localparam int HORNER_FIRST = 4;
  localparam int HORNER_LAST  = 10;
  localparam int ST_TRIG      = 11;
  localparam int ST_COUP      = 12;
  localparam int ST_CORR_MUL  = 13;
  localparam int ST_ROLL      = 14;
  localparam int DIV_FIRST    = 12;
  localparam int DIV_LAST     = 19;
  localparam int DIV_PER_ST   = 2;
  localparam int ST_OUT       = 20;

  localparam int SAT_CD        = 4500;
  localparam int COS_FLOOR_Q15 = 9830;
  localparam int HALF_TURN_CD  = 18000;
  localparam int QUARTER_CD    = 9000;
  localparam int EIGHTH_CD     = 4500;

  // trig arithmetic in q34
  localparam longint Q34    = longint'(1) << 34;
  localparam longint PI_Q60 = 64'h3243F6A8885A308D;
  // pi/18000 in q48: radians per centidegree
  localparam longint KX     = ((PI_Q60 >>> 12) + 9000) / 18000;

  typedef struct packed {
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic signed [14:0] yaw;
    logic signed [30:0] pm;
    logic signed [30:0] ym;
    logic signed [30:0] rm;
    logic signed [16:0] pr;
    logic signed [16:0] yr;
    logic signed [16:0] rr;
    logic [14:0]        ang;
    logic               sneg;
    logic               cneg;
    logic               swp;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [13:0] rotc;
    logic [33:0]        x;
    logic [33:0]        x2;
    logic signed [35:0] sacc;
    logic signed [35:0] cacc;
    logic signed [17:0] s;
    logic [15:0]        c;
    logic signed [47:0] m;
    logic signed [14:0] rc;
    logic [15:0]        rem;
    logic [15:0]        nbits;
    logic [15:0]        quo;
    logic               pneg;
    logic signed [14:0] pc;
  } item_t;

  function automatic logic signed [35:0] cos_coef(input logic [2:0] idx);
    logic signed [35:0] v;
    case (idx)
      3'd0:    v = 36'(Q34);
      3'd1:    v = -36'(Q34 / 2);
      3'd2:    v = 36'((Q34 + 12) / 24);
      3'd3:    v = -36'((Q34 + 360) / 720);
      3'd4:    v = 36'((Q34 + 20160) / 40320);
      3'd5:    v = -36'((Q34 + 1814400) / 3628800);
      3'd6:    v = 36'((Q34 + 239500800) / 479001600);
      default: v = -36'((Q34 + 43589145600) / 87178291200);
    endcase
    return v;
  endfunction

  function automatic logic signed [35:0] sin_coef(input logic [2:0] idx);
    logic signed [35:0] v;
    case (idx)
      3'd0:    v = 36'(Q34);
      3'd1:    v = -36'((Q34 + 3) / 6);
      3'd2:    v = 36'((Q34 + 60) / 120);
      3'd3:    v = -36'((Q34 + 2520) / 5040);
      3'd4:    v = 36'((Q34 + 181440) / 362880);
      3'd5:    v = -36'((Q34 + 19958400) / 39916800);
      3'd6:    v = 36'((Q34 + 3113510400) / 6227020800);
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat_cd(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd4500) begin
      r = 16'(SAT_CD);
    end else if (v < -18'sd4500) begin
      r = -16'(SAT_CD);
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  // load stage: raw fields, gain products, angle magnitude
  function automatic item_t entry_fn(input logic signed [14:0] roll,
                                     input logic signed [14:0] pitch,
                                     input logic signed [14:0] yaw,
                                     input logic signed [14:0] rot,
                                     input cfg_t cfg);
    item_t o;
    o = '0;
    o.roll  = roll;
    o.pitch = pitch;
    o.yaw   = yaw;
    o.pm    = 31'(pitch) * $signed({16'd0, cfg.pitch_mix});
    o.ym    = 31'(yaw) * $signed({16'd0, cfg.yaw_mix});
    o.rm    = 31'(roll) * $signed({16'd0, cfg.roll_mix});
    o.sneg  = rot[14];
    o.ang   = rot[14] ? 15'(-rot) : 15'(rot);
    return o;
  endfunction

  function automatic item_t stage_fn(input int k, input item_t i, input cfg_t cfg);
    item_t              o;
    logic [14:0]        a;
    logic signed [17:0] sum_l;
    logic signed [17:0] sum_r;
    logic [12:0]        lim;
    logic signed [71:0] pw;
    logic [16:0]        sv;
    logic [16:0]        cv;
    logic [16:0]        tv;
    logic signed [17:0] cn;
    logic [14:0]        mag;
    logic [16:0]        t;
    logic signed [47:0] corr;
    logic signed [17:0] rsum;
    logic [15:0]        qm;
    o = i;
    case (k)
      ST_ROUND: begin
        o.pr = 17'((i.pm + 31'sd8192) >>> 14);
        o.yr = 17'((i.ym + 31'sd8192) >>> 14);
        o.rr = 17'((i.rm + 31'sd8192) >>> 14);
        a = i.ang;
        if (a > 15'(QUARTER_CD)) begin
          a = 15'(HALF_TURN_CD) - a;
          o.cneg = 1'b1;
        end
        if (a > 15'(EIGHTH_CD)) begin
          a = 15'(QUARTER_CD) - a;
          o.swp = 1'b1;
        end
        o.ang = a;
      end
      ST_ANGLE: begin
        o.x = 34'(((49'(i.ang[12:0]) * 49'(KX)) + 49'd8192) >> 14);
        sum_l = 18'(i.pr) + 18'(i.yr) + 18'(i.rr);
        sum_r = 18'(i.pr) - 18'(i.yr) - 18'(i.rr);
        lim = (cfg.rot_limit > 13'(SAT_CD)) ? 13'(SAT_CD) : cfg.rot_limit;
        if (cfg.enable) begin
          o.left  = sat_cd(sum_l);
          o.right = sat_cd(sum_r);
          if (i.yaw > $signed({2'b0, lim})) begin
            o.rotc = $signed({1'b0, lim});
          end else if (i.yaw < -$signed({2'b0, lim})) begin
            o.rotc = -$signed({1'b0, lim});
          end else begin
            o.rotc = 14'(i.yaw);
          end
        end else begin
          o.left  = 16'(i.pitch) + 16'(i.yaw);
          o.right = 16'(i.pitch) - 16'(i.yaw);
          o.rotc  = '0;
        end
      end
      ST_SQUARE: begin
        o.x2   = 34'((68'(i.x) * 68'(i.x)) >> 34);
        o.cacc = cos_coef(3'd7);
        o.sacc = sin_coef(3'd6);
      end
      ST_TRIG: begin
        sv = 17'((i.sacc + 36'sd262144) >>> 19);
        cv = 17'((i.cacc + 36'sd262144) >>> 19);
        if (i.swp) begin
          tv = sv;
          sv = cv;
          cv = tv;
        end
        o.s = i.sneg ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
        cn  = i.cneg ? -$signed({1'b0, cv}) : $signed({1'b0, cv});
        o.c = (cn < 18'sd9830) ? 16'(COS_FLOOR_Q15) : 16'(cn);
        // long division setup: |pitch|<<15 over c, top bits already below c
        mag     = i.pitch[14] ? 15'(-i.pitch) : 15'(i.pitch);
        o.pneg  = i.pitch[14];
        o.rem   = 16'(mag >> 1);
        o.nbits = {mag[0], 15'd0};
        o.quo   = '0;
      end
      ST_CORR_MUL: begin
        o.m = 48'(i.m * 48'sd4500);
        for (int d = 0; d < DIV_PER_ST; d++) begin
          t = {o.rem, o.nbits[15]};
          o.nbits = {o.nbits[14:0], 1'b0};
          if (t >= {1'b0, i.c}) begin
            o.rem = 16'(t - {1'b0, i.c});
            o.quo = {o.quo[14:0], 1'b1};
          end else begin
            o.rem = t[15:0];
            o.quo = {o.quo[14:0], 1'b0};
          end
        end
      end
      ST_ROLL: begin
        corr = (-i.m + 48'sd268435456) >>> 29;
        rsum = 18'(i.roll) + 18'(corr);
        o.rc = (cfg.coup_gain == '0) ? i.roll : 15'(sat_cd(rsum));
        for (int d = 0; d < DIV_PER_ST; d++) begin
          t = {o.rem, o.nbits[15]};
          o.nbits = {o.nbits[14:0], 1'b0};
          if (t >= {1'b0, i.c}) begin
            o.rem = 16'(t - {1'b0, i.c});
            o.quo = {o.quo[14:0], 1'b1};
          end else begin
            o.rem = t[15:0];
            o.quo = {o.quo[14:0], 1'b0};
          end
        end
      end
      ST_OUT: begin
        qm = (i.quo > 16'(SAT_CD)) ? 16'(SAT_CD) : i.quo;
        if (cfg.enable) begin
          o.pc = i.pneg ? -15'(qm) : 15'(qm);
        end else begin
          o.pc = i.pitch;
          o.rc = i.roll;
        end
      end
      default: begin
        if (k >= HORNER_FIRST && k <= HORNER_LAST) begin
          pw     = 72'(i.cacc) * $signed({38'd0, i.x2});
          o.cacc = 36'(pw >>> 34) + cos_coef(3'(HORNER_LAST - k));
          if (k < HORNER_LAST) begin
            pw     = 72'(i.sacc) * $signed({38'd0, i.x2});
            o.sacc = 36'(pw >>> 34) + sin_coef(3'(HORNER_LAST - 1 - k));
          end else begin
            pw     = 72'(i.sacc) * $signed({38'd0, i.x});
            o.sacc = 36'(pw >>> 34);
          end
        end
        if (k == ST_COUP) begin
          o.m = 48'(cfg.coup_gain) * 48'(i.s);
        end
        if (k >= DIV_FIRST && k <= DIV_LAST) begin
          for (int d = 0; d < DIV_PER_ST; d++) begin
            t = {o.rem, o.nbits[15]};
            o.nbits = {o.nbits[14:0], 1'b0};
            if (t >= {1'b0, i.c}) begin
              o.rem = 16'(t - {1'b0, i.c});
              o.quo = {o.quo[14:0], 1'b1};
            end else begin
              o.rem = t[15:0];
              o.quo = {o.quo[14:0], 1'b0};
            end
          end
        end
      end
    endcase
    return o;
  endfunction

endpackage

/* hdl/tsm_regs.sv */
`timescale 1ns / 1ps
// tail surface mixer configuration registers behind an apb-style port
// depends on tsm_pkg
module tsm_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tsm_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output tsm_pkg::cfg_t               cfg
);

  tsm_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= tsm_pkg::RST_ENABLE;
      cfg_r.yaw_mix   <= tsm_pkg::RST_YAW_MIX;
      cfg_r.roll_mix  <= tsm_pkg::RST_ROLL_MIX;
      cfg_r.pitch_mix <= tsm_pkg::RST_PITCH_MIX;
      cfg_r.rot_limit <= tsm_pkg::RST_ROT_LIMIT;
      cfg_r.coup_gain <= '0;
    end else if (wr_en) begin
      case (idx)
        tsm_pkg::REG_ENABLE:    cfg_r.enable    <= cfg_pwdata[0];
        tsm_pkg::REG_YAW_MIX:   cfg_r.yaw_mix   <= cfg_pwdata[14:0];
        tsm_pkg::REG_ROLL_MIX:  cfg_r.roll_mix  <= cfg_pwdata[14:0];
        tsm_pkg::REG_PITCH_MIX: cfg_r.pitch_mix <= cfg_pwdata[14:0];
        tsm_pkg::REG_ROT_LIMIT: cfg_r.rot_limit <= cfg_pwdata[12:0];
        tsm_pkg::REG_COUP_GAIN: cfg_r.coup_gain <= $signed(cfg_pwdata[16:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tsm_pkg::REG_ENABLE:    cfg_prdata = {31'd0, cfg_r.enable};
      tsm_pkg::REG_YAW_MIX:   cfg_prdata = {17'd0, cfg_r.yaw_mix};
      tsm_pkg::REG_ROLL_MIX:  cfg_prdata = {17'd0, cfg_r.roll_mix};
      tsm_pkg::REG_PITCH_MIX: cfg_prdata = {17'd0, cfg_r.pitch_mix};
      tsm_pkg::REG_ROT_LIMIT: cfg_prdata = {19'd0, cfg_r.rot_limit};
      tsm_pkg::REG_COUP_GAIN: cfg_prdata = 32'(cfg_r.coup_gain);
      default:                cfg_prdata = '0;
    endcase
  end

endmodule

/* hdl/tail_surface_mixer_unit.sv */
`timescale 1ns / 1ps
// tail surface mixer top level: stream ports, 21-stage datapath pipeline
// depends on tsm_pkg and tsm_regs
//
// Takes one demand set (roll, pitch, yaw, tail rotation, centidegrees) per
// clock and returns one result of five values for each set. Throughput is
// one item per cycle; the pipeline stalls as a whole only where a stage
// holds an item that the next stage cannot take, so bubbles are squeezed out
// while the output waits. Latency is set by the trig path: sine and cosine
// of the reduced rotation come from a seven-step Horner series in q34 (two
// multiplies per stage), and pitch/cos uses a radix-2 restoring divider that
// retires two quotient bits per stage over eight stages. Config registers
// are meant to be written only while the pipeline is empty.
module tail_surface_mixer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: roll_demand[14:0], pitch_demand[29:15], yaw_demand[44:30],
  //           rotation_angle[59:45], zero pad[63:60]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // out_tdata: left_surface[15:0], right_surface[31:16],
  //            rotator_command[45:32], pitch_compensated[60:46],
  //            roll_compensated[75:61], zero pad[79:76]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NST = tsm_pkg::NSTAGE;

  tsm_pkg::cfg_t  cfg;
  tsm_pkg::item_t pipe_r   [NST];
  tsm_pkg::item_t pipe_nxt [NST];
  logic [NST-1:0] valid_r;
  logic [NST-1:0] rdy;

  tsm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // a stage can load when empty or when the stage after it moves on
  always_comb begin
    rdy[NST-1] = !valid_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    if (k == tsm_pkg::ST_ENTRY) begin : g_entry
      // entry stage: unpack item, start gain products and angle fold
      always_comb begin
        pipe_nxt[k] = tsm_pkg::entry_fn($signed(in_tdata[14:0]),
                                        $signed(in_tdata[29:15]),
                                        $signed(in_tdata[44:30]),
                                        $signed(in_tdata[59:45]), cfg);
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          valid_r[k] <= in_tvalid;
        end
      end
    end else begin : g_work
      always_comb begin
        pipe_nxt[k] = tsm_pkg::stage_fn(k, pipe_r[k-1], cfg);
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
    // payload, no reset needed
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // last stage doubles as the output register
  assign out_tvalid = valid_r[NST-1];
  assign out_tdata  = {4'd0,
                       pipe_r[NST-1].rc,
                       pipe_r[NST-1].pc,
                       pipe_r[NST-1].rotc,
                       pipe_r[NST-1].right,
                       pipe_r[NST-1].left};

endmodule
